FILE: sv/bsfe_pkg.sv
// Shared types, sizes and codes of the byte stream frame extractor.
package bsfe_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int CAP       = (BUF_DEPTH < 64) ? BUF_DEPTH : 64;
    localparam int ADDR_W    = $clog2(CAP);
    localparam int FILL_W    = $clog2(CAP + 1);

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 6;
    localparam int LEN_W     = 7;
    localparam int PAY_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int OUT_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_OFFSET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_BYTES    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_BYTES  = 3'd7;

    localparam logic [1:0] MODE_FIXED     = 2'd0;
    localparam logic [1:0] MODE_DELIMITER = 2'd1;
    localparam logic [1:0] MODE_LENGTH    = 2'd2;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_READ,
        ST_LOAD
    } t_state;

endpackage

FILE: sv/byte_stream_frame_extractor.sv
// Top level of the byte stream frame extractor: framing control, frame store and output stage.
//
// Received bytes are taken one per cycle while a frame is being collected and written
// into a 64-byte frame store. When a frame completes in fixed, delimiter or length
// mode, its n bytes stream out in order, each byte being a read of the store's single
// read port followed by a load of the output register; the input side is held off
// until the last byte is loaded, also while the output side stalls, and the last byte
// may still wait in the output register while collection resumes. The store needs no
// clearing after reset. Configuration writes abandon a frame in progress.
module byte_stream_frame_extractor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [bsfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bsfe_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bsfe_pkg::OUT_W-1:0]       m_axis_tdata,  // [7:0] frame_byte,
                                                            // [13:8] byte_position,
                                                            // [20:14] frame_length, zero pad
    output logic                             m_axis_tlast   // last_byte
);
    import bsfe_pkg::*;

    t_state r_state, n_state;

    logic [1:0]        r_mode;
    logic [BYTE_W-1:0] r_head, r_tail, r_delim;
    logic [LEN_W-1:0]  r_fixed_len;
    logic [5:0]        r_len_off;
    logic [1:0]        r_len_bytes;
    logic [2:0]        r_check;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [PAY_W-1:0]  r_payload, n_payload;
    logic [BYTE_W-1:0] r_len_lo, r_len_hi;
    logic [FILL_W-1:0] r_emit_len, n_emit_len;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_last;

    logic              in_beat, wr_en, start_emit, load_out, last_read;
    logic [BYTE_W-1:0] rx, rd_data;
    logic [FILL_W-1:0] nf, len_sat, cap_c;
    logic [1:0]        lb_eff;
    logic [LEN_W-1:0]  hdr;
    logic [PAY_W-1:0]  pay_field;
    logic [PAY_W:0]    total;

    assign rx      = s_axis_tdata;
    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign cap_c   = FILL_W'(CAP);
    assign nf      = r_fill + 1'b1;

    always_comb begin
        if (r_fixed_len < 7'd2) begin
            len_sat = FILL_W'(2);
        end else if (r_fixed_len > cap_c) begin
            len_sat = cap_c;
        end else begin
            len_sat = r_fixed_len;
        end
        if (r_len_bytes == 2'd0) begin
            lb_eff = 2'd1;
        end else if (r_len_bytes == 2'd3) begin
            lb_eff = 2'd2;
        end else begin
            lb_eff = r_len_bytes;
        end
        hdr       = {1'b0, r_len_off} + LEN_W'(lb_eff) + LEN_W'(r_check) + 7'd1;
        pay_field = (lb_eff == 2'd1) ? {8'd0, r_len_lo} : {r_len_hi, r_len_lo};
        total     = (PAY_W + 1)'(hdr) + {1'b0, r_payload};
    end

    // Frame collection: decides on each accepted byte whether it is stored and
    // whether a frame is complete.
    always_comb begin
        n_fill     = r_fill;
        n_payload  = r_payload;
        n_emit_len = r_emit_len;
        wr_en      = 1'b0;
        start_emit = 1'b0;
        if (in_beat) begin
            case (r_mode)
                MODE_FIXED: begin
                    if (r_fill == '0) begin
                        if (rx == r_head) begin
                            wr_en  = 1'b1;
                            n_fill = nf;
                        end
                    end else if (r_fill < len_sat - 1'b1) begin
                        wr_en  = 1'b1;
                        n_fill = nf;
                    end else begin
                        n_fill = '0;
                        if (rx == r_tail && r_fill == len_sat - 1'b1) begin
                            wr_en      = 1'b1;
                            start_emit = 1'b1;
                            n_emit_len = len_sat;
                        end
                    end
                end
                MODE_DELIMITER: begin
                    if (r_fill < cap_c) begin
                        wr_en  = 1'b1;
                        n_fill = nf;
                    end else begin
                        n_fill = '0;
                    end
                    if (rx == r_delim) begin
                        n_fill = '0;
                        if (r_fill < cap_c) begin
                            start_emit = 1'b1;
                            n_emit_len = nf;
                        end
                    end
                end
                MODE_LENGTH: begin
                    if (r_fill == '0) begin
                        if (rx == r_head) begin
                            wr_en  = 1'b1;
                            n_fill = nf;
                        end
                    end else if (r_fill < cap_c) begin
                        wr_en  = 1'b1;
                        n_fill = nf;
                        if (LEN_W'(nf) == hdr) begin
                            n_payload = pay_field;
                            if (pay_field == '0) begin
                                n_fill = '0;
                            end
                        end else if (LEN_W'(nf) > hdr) begin
                            if ((PAY_W + 1)'(nf) == total) begin
                                n_fill = '0;
                                if (rx == r_tail) begin
                                    start_emit = 1'b1;
                                    n_emit_len = nf;
                                end
                            end
                        end
                    end else begin
                        n_fill = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The store is written only while collecting and read only while emitting,
    // so the two ports never touch the same entry in one cycle.
    bsfe_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(CAP)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_fill[ADDR_W-1:0]),
        .i_wdata(rx),
        .i_raddr(r_rd_idx),
        .o_rdata(rd_data)
    );

    assign last_read = ({1'b0, r_rd_idx} == r_emit_len - 1'b1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (start_emit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = last_read ? ST_COLLECT : ST_READ;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        n_rd_idx      = r_rd_idx;
        case (r_state)
            ST_COLLECT: begin
                s_axis_tready = 1'b1;
                n_rd_idx      = '0;
            end
            ST_READ: begin
            end
            ST_LOAD: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_mode      <= MODE_FIXED;
            r_head      <= '0;
            r_tail      <= '0;
            r_fixed_len <= 7'd2;
            r_delim     <= '0;
            r_len_off   <= 6'd1;
            r_len_bytes <= 2'd1;
            r_check     <= '0;
            r_fill      <= '0;
            r_payload   <= '0;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
            r_emit_len  <= FILL_W'(1);
        end else begin
            r_state    <= n_state;
            r_rd_idx   <= n_rd_idx;
            r_emit_len <= n_emit_len;
            if (i_cfg_wen) begin
                r_fill    <= '0;
                r_payload <= '0;
                case (i_cfg_index)
                    REG_FRAME_MODE:   r_mode      <= i_cfg_data[1:0];
                    REG_HEAD_BYTE:    r_head      <= i_cfg_data;
                    REG_TAIL_BYTE:    r_tail      <= i_cfg_data;
                    REG_FIXED_LENGTH: r_fixed_len <= i_cfg_data[LEN_W-1:0];
                    REG_DELIMITER:    r_delim     <= i_cfg_data;
                    REG_LEN_OFFSET:   r_len_off   <= i_cfg_data[5:0];
                    REG_LEN_BYTES:    r_len_bytes <= i_cfg_data[1:0];
                    REG_CHECK_BYTES:  r_check     <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end else begin
                r_fill    <= n_fill;
                r_payload <= n_payload;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The length field is captured as its bytes are stored, and the output register is loaded from the store.
    always_ff @(posedge i_clk) begin
        if (wr_en && {1'b0, r_fill} == {2'b0, r_len_off}) begin
            r_len_lo <= rx;
        end
        if (wr_en && {1'b0, r_fill} == {2'b0, r_len_off} + 8'd1) begin
            r_len_hi <= rx;
        end
        if (load_out) begin
            r_out_data <= {3'b000, LEN_W'(r_emit_len), POS_W'(r_rd_idx), rd_data};
            r_out_last <= last_read;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: sv/bsfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bsfe_checker.sv
// Port-level checker for the byte stream frame extractor, bound to the top level.
module bsfe_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [bsfe_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tlast
);
    import bsfe_pkg::*;

    logic             out_beat;
    logic [POS_W-1:0] r_exp_pos;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;

    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign pos      = m_axis_tdata[13:8];
    assign len      = m_axis_tdata[20:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pos <= '0;
        end else if (out_beat) begin
            r_exp_pos <= m_axis_tlast ? '0 : pos + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("Stalled output beat changed.");

    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> pos == r_exp_pos)
        else $error("Frame byte out of order.");

    a_last_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> m_axis_tlast == ({1'b0, pos} + 7'd1 == len))
        else $error("Last flag does not match frame length.");

    a_no_input_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("Input accepted while a frame is still streaming out.");

endmodule

bind byte_stream_frame_extractor bsfe_checker u_bsfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
